// File: sv/cbrd_pkg.sv
`timescale 1ns / 1ps

package cbrd_pkg;

   localparam int MAX_EDGES = 128;
   localparam int EDGE_W    = 8;
   localparam int TICK_W    = 32;
   localparam int SLOW_W    = 16;
   localparam int DISC_W    = 7;
   localparam int CSR_W     = 32;
   localparam int CSR_IDX_W = 2;

   localparam logic [SLOW_W-1:0] SLOW_BIT_TICKS_RST  = SLOW_W'(1728);
   localparam logic [TICK_W-1:0] WINDOW_TICKS_RST    = TICK_W'(43200000);
   localparam logic [EDGE_W-1:0] EDGES_NEEDED_RST    = EDGE_W'(32);
   localparam logic [DISC_W-1:0] EDGES_DISCARDED_RST = DISC_W'(8);

   typedef enum logic [1:0] {
      ST_CLASSIFIED = 2'd0,
      ST_LOCKED     = 2'd1,
      ST_TOO_FEW    = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SLOW_BIT_TICKS  = 2'd0,
      CSR_WINDOW_TICKS    = 2'd1,
      CSR_EDGES_NEEDED    = 2'd2,
      CSR_EDGES_DISCARDED = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      SPEED_125K = 2'd0,
      SPEED_250K = 2'd1,
      SPEED_500K = 2'd2,
      SPEED_1M   = 2'd3
   } speed_type;

   typedef struct packed {
      logic              close;
      logic              frame;
      logic [EDGE_W-1:0] edges;
      logic [TICK_W-1:0] min_interval;
   } win_result_type;

   // Walk the halving threshold ladder from the slowest rate upward.
   function automatic speed_type ladder(input logic [TICK_W-1:0] interval,
                                        input logic [SLOW_W-1:0] slow_ticks);
      logic [SLOW_W-1:0] thr0;
      logic [SLOW_W-1:0] thr1;
      logic [SLOW_W-1:0] thr2;
      speed_type         spd;
      thr0 = slow_ticks - (slow_ticks >> 2);
      thr1 = thr0 >> 1;
      thr2 = thr0 >> 2;
      spd  = SPEED_125K;
      if (interval < TICK_W'(thr0)) begin
         spd = SPEED_250K;
         if (interval < TICK_W'(thr1)) begin
            spd = SPEED_500K;
            if (interval < TICK_W'(thr2)) begin
               spd = SPEED_1M;
            end
         end
      end
      return spd;
   endfunction

endpackage

// File: sv/cbrd_chan_if.sv
`timescale 1ns / 1ps

interface can_req_if;
   logic valid;
   logic ready;
   logic rx_level;
   logic frame_seen;

   modport source (output valid, output rx_level, output frame_seen, input ready);
   modport sink   (input valid, input rx_level, input frame_seen, output ready);
endinterface

interface can_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   status;
   logic [1:0]                   speed_code;
   logic [cbrd_pkg::TICK_W-1:0]  min_interval;
   logic [cbrd_pkg::EDGE_W-1:0]  edge_total;

   modport source (output valid, output status, output speed_code,
                   output min_interval, output edge_total, input ready);
   modport sink   (input valid, input status, input speed_code,
                   input min_interval, input edge_total, output ready);
endinterface

// File: sv/cbrd_window.sv
`timescale 1ns / 1ps

module cbrd_window (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic                                rx_level,
   input  logic                                frame_seen,
   input  logic [cbrd_pkg::TICK_W-1:0]         window_ticks,
   input  logic [cbrd_pkg::DISC_W-1:0]         edges_discarded,
   output cbrd_pkg::win_result_type            win
);

   logic                          last_level_ff;
   logic [cbrd_pkg::TICK_W-1:0]   elapsed_ff;
   logic [cbrd_pkg::EDGE_W-1:0]   edge_count_ff;
   logic [cbrd_pkg::TICK_W-1:0]   even_time_ff;
   logic [cbrd_pkg::TICK_W-1:0]   min_seen_ff;
   logic                          frame_ff;

   logic                          edge_hit;
   logic [cbrd_pkg::TICK_W-1:0]   interval;
   logic                          take_min;
   logic [cbrd_pkg::TICK_W-1:0]   min_in;
   logic [cbrd_pkg::EDGE_W-1:0]   edge_count_in;
   logic [cbrd_pkg::TICK_W-1:0]   elapsed_in;
   logic [cbrd_pkg::TICK_W-1:0]   even_time_in;
   logic                          frame_in;
   logic                          close;

   always_comb begin
      edge_hit      = rx_level != last_level_ff;
      interval      = elapsed_ff - even_time_ff;
      take_min      = edge_hit && edge_count_ff[0]
                      && ((edge_count_ff - 1'b1) > cbrd_pkg::EDGE_W'(edges_discarded))
                      && (interval < min_seen_ff);
      min_in        = take_min ? interval : min_seen_ff;
      edge_count_in = edge_hit ? edge_count_ff + 1'b1 : edge_count_ff;
      even_time_in  = (edge_hit && !edge_count_ff[0]) ? elapsed_ff : even_time_ff;
      elapsed_in    = elapsed_ff + 1'b1;
      frame_in      = frame_ff | frame_seen;
      close         = (edge_count_in >= cbrd_pkg::EDGE_W'(cbrd_pkg::MAX_EDGES))
                      || !(elapsed_in < window_ticks);
      win.close        = close;
      win.frame        = frame_in;
      win.edges        = edge_count_in;
      win.min_interval = min_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_level_ff <= 1'b0;
         elapsed_ff    <= '0;
         edge_count_ff <= '0;
         even_time_ff  <= '0;
         min_seen_ff   <= '1;
         frame_ff      <= 1'b0;
      end else if (advance) begin
         last_level_ff <= rx_level;
         if (close) begin
            elapsed_ff    <= '0;
            edge_count_ff <= '0;
            even_time_ff  <= '0;
            min_seen_ff   <= '1;
            frame_ff      <= 1'b0;
         end else begin
            elapsed_ff    <= elapsed_in;
            edge_count_ff <= edge_count_in;
            even_time_ff  <= even_time_in;
            min_seen_ff   <= min_in;
            frame_ff      <= frame_in;
         end
      end
   end

   property p_edges_bounded;
      @(posedge clock) disable iff (reset)
         edge_count_ff < cbrd_pkg::EDGE_W'(cbrd_pkg::MAX_EDGES);
   endproperty
   a_edges_bounded: assert property (p_edges_bounded)
      else $error("edge count reached the window limit without closing");

   property p_min_only_from_odd;
      @(posedge clock) disable iff (reset)
         advance && !close && take_min |=> min_seen_ff == $past(interval);
   endproperty
   a_min_only_from_odd: assert property (p_min_only_from_odd)
      else $error("minimum interval not captured");

   property p_close_clears;
      @(posedge clock) disable iff (reset)
         advance && close |=> edge_count_ff == '0 && min_seen_ff == '1 && !frame_ff;
   endproperty
   a_close_clears: assert property (p_close_clears)
      else $error("window state not cleared at close");

endmodule

// File: sv/can_bit_rate_detector_core.sv
`timescale 1ns / 1ps

// CAN bit-rate detector. Each beat on req_chan is one sample tick of the
// receive line (rx_level) plus the controller's frame-received flag
// (frame_seen). A measurement window closes after MAX_EDGES level changes
// or after window_ticks ticks; each closed window yields one beat on
// rsp_chan with status, speed_code, min_interval and edge_total. Ticks
// that do not close a window yield nothing.
// An accepted beat lands in an input register and is processed from there;
// a result passes through the input register and then the result register
// before it appears on rsp_chan. One tick per clock is sustained while no
// closing tick waits on a pending result: the input register and the result register are the only stages.
// When rsp_chan stalls with a result pending, further ticks still flow
// through as long as they do not close a window; a closing tick waits in
// the input register, and req_chan.ready drops once that register is held.
// Reset (synchronous, active high) clears the window, selects 125 kbit/s and
// restores the default configuration. csr_we writes register csr_index from
// csr_wdata; the user must write only while the block is idle; it is not enforced.
module can_bit_rate_detector_core (
   input  logic                                 clock,
   input  logic                                 reset,
   can_req_if.sink                              req_chan,
   can_rsp_if.source                            rsp_chan,
   input  logic                                 csr_we,
   input  logic [cbrd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [cbrd_pkg::CSR_W-1:0]           csr_wdata
);

   logic [cbrd_pkg::SLOW_W-1:0]   slow_bit_ticks_ff;
   logic [cbrd_pkg::TICK_W-1:0]   window_ticks_ff;
   logic [cbrd_pkg::EDGE_W-1:0]   edges_needed_ff;
   logic [cbrd_pkg::DISC_W-1:0]   edges_discarded_ff;

   logic                          in_valid_ff;
   logic                          rx_level_ff;
   logic                          frame_seen_ff;

   cbrd_pkg::speed_type           current_speed_ff;
   cbrd_pkg::speed_type           current_speed_in;

   logic                          rsp_valid_ff;
   cbrd_pkg::status_type          status_ff;
   cbrd_pkg::status_type          status_in;
   cbrd_pkg::speed_type           speed_ff;
   cbrd_pkg::speed_type           speed_in;
   logic [cbrd_pkg::TICK_W-1:0]   min_interval_ff;
   logic [cbrd_pkg::EDGE_W-1:0]   edge_total_ff;

   cbrd_pkg::win_result_type      win;
   logic                          advance;
   logic                          load_rsp;

   // Configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         slow_bit_ticks_ff  <= cbrd_pkg::SLOW_BIT_TICKS_RST;
         window_ticks_ff    <= cbrd_pkg::WINDOW_TICKS_RST;
         edges_needed_ff    <= cbrd_pkg::EDGES_NEEDED_RST;
         edges_discarded_ff <= cbrd_pkg::EDGES_DISCARDED_RST;
      end else if (csr_we) begin
         case (cbrd_pkg::csr_index_type'(csr_index))
            cbrd_pkg::CSR_SLOW_BIT_TICKS: begin
               slow_bit_ticks_ff <= csr_wdata[cbrd_pkg::SLOW_W-1:0];
            end
            cbrd_pkg::CSR_WINDOW_TICKS: begin
               window_ticks_ff <= csr_wdata[cbrd_pkg::TICK_W-1:0];
            end
            cbrd_pkg::CSR_EDGES_NEEDED: begin
               edges_needed_ff <= csr_wdata[cbrd_pkg::EDGE_W-1:0];
            end
            cbrd_pkg::CSR_EDGES_DISCARDED: begin
               edges_discarded_ff <= csr_wdata[cbrd_pkg::DISC_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Hold a closing tick while an unaccepted result occupies the output.
   assign advance          = in_valid_ff && (!win.close || !rsp_valid_ff || rsp_chan.ready);
   assign load_rsp         = advance && win.close;
   assign req_chan.ready   = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         rx_level_ff   <= req_chan.rx_level;
         frame_seen_ff <= req_chan.frame_seen;
      end
   end

   cbrd_window u_window (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .rx_level        (rx_level_ff),
      .frame_seen      (frame_seen_ff),
      .window_ticks    (window_ticks_ff),
      .edges_discarded (edges_discarded_ff),
      .win             (win)
   );

   always_comb begin
      current_speed_in = current_speed_ff;
      if (win.frame) begin
         status_in = cbrd_pkg::ST_LOCKED;
         speed_in  = current_speed_ff;
      end else if (win.edges < edges_needed_ff) begin
         status_in = cbrd_pkg::ST_TOO_FEW;
         speed_in  = current_speed_ff;
      end else begin
         status_in        = cbrd_pkg::ST_CLASSIFIED;
         speed_in         = cbrd_pkg::ladder(win.min_interval, slow_bit_ticks_ff);
         current_speed_in = speed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         current_speed_ff <= cbrd_pkg::SPEED_125K;
         rsp_valid_ff     <= 1'b0;
      end else if (load_rsp) begin
         current_speed_ff <= current_speed_in;
         rsp_valid_ff     <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff     <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         status_ff       <= status_in;
         speed_ff        <= speed_in;
         min_interval_ff <= win.min_interval;
         edge_total_ff   <= win.edges;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = status_ff;
   assign rsp_chan.speed_code   = speed_ff;
   assign rsp_chan.min_interval = min_interval_ff;
   assign rsp_chan.edge_total   = edge_total_ff;

   property p_classified_is_current;
      @(posedge clock) disable iff (reset)
         rsp_valid_ff && (status_ff == cbrd_pkg::ST_CLASSIFIED)
            |-> current_speed_ff == speed_ff;
   endproperty
   a_classified_is_current: assert property (p_classified_is_current)
      else $error("classified speed differs from current speed");

   property p_no_overwrite;
      @(posedge clock) disable iff (reset)
         rsp_valid_ff && !rsp_chan.ready |-> !load_rsp;
   endproperty
   a_no_overwrite: assert property (p_no_overwrite)
      else $error("pending result overwritten");

   property p_edge_total_bounded;
      @(posedge clock) disable iff (reset)
         rsp_valid_ff |-> edge_total_ff <= cbrd_pkg::EDGE_W'(cbrd_pkg::MAX_EDGES);
   endproperty
   a_edge_total_bounded: assert property (p_edge_total_bounded)
      else $error("edge total above window limit");

   property p_hold_input;
      @(posedge clock) disable iff (reset)
         in_valid_ff && !advance |=> in_valid_ff && $stable(rx_level_ff)
                                      && $stable(frame_seen_ff);
   endproperty
   a_hold_input: assert property (p_hold_input)
      else $error("stalled tick lost from input register");

endmodule

// File: tb/cbrd_checker.sv
`timescale 1ns / 1ps

module cbrd_checker
   import cbrd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   can_req_if                   req_mon,
   can_rsp_if                   rsp_mon,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   output int                   fail_count,
   output int                   reports_due
);

   typedef struct packed {
      status_type        status;
      speed_type         speed;
      logic [TICK_W-1:0] min_interval;
      logic [EDGE_W-1:0] edge_total;
   } window_report_t;

   logic [SLOW_W-1:0] bit_ticks_cfg;
   logic [TICK_W-1:0] window_cfg;
   logic [EDGE_W-1:0] need_cfg;
   logic [DISC_W-1:0] drop_cfg;

   logic              line_q;
   logic [TICK_W-1:0] elapsed;
   logic [EDGE_W-1:0] edges_seen;
   logic [TICK_W-1:0] pair_start;
   logic [TICK_W-1:0] shortest;
   logic              frame_hold;
   speed_type         speed_now;

   window_report_t    report_q[$];

   function automatic speed_type pick_speed(input logic [TICK_W-1:0] span);
      logic [TICK_W-1:0] limit;
      int unsigned       step;
      limit = TICK_W'(bit_ticks_cfg) - TICK_W'(bit_ticks_cfg >> 2);
      step  = 0;
      while (span < limit && step < 3) begin
         step++;
         limit = limit >> 1;
      end
      return speed_type'(step[1:0]);
   endfunction

   task automatic open_window();
      elapsed    = '0;
      edges_seen = '0;
      pair_start = '0;
      shortest   = '1;
      frame_hold = 1'b0;
   endtask

   task automatic take_tick(input logic lvl, input logic frm);
      logic [TICK_W-1:0] now;
      logic [TICK_W-1:0] span;
      window_report_t    rep;
      now = elapsed;
      if (frm) begin
         frame_hold = 1'b1;
      end
      if (lvl != line_q) begin
         if (!edges_seen[0]) begin
            pair_start = now;
         end else begin
            span = now - pair_start;
            if (edges_seen - 1 > drop_cfg && span < shortest) begin
               shortest = span;
            end
         end
         edges_seen = edges_seen + 1'b1;
      end
      line_q  = lvl;
      elapsed = now + 1'b1;
      if (edges_seen >= MAX_EDGES || elapsed >= window_cfg) begin
         if (frame_hold) begin
            rep.status = ST_LOCKED;
            rep.speed  = speed_now;
         end else if (edges_seen < need_cfg) begin
            rep.status = ST_TOO_FEW;
            rep.speed  = speed_now;
         end else begin
            rep.status = ST_CLASSIFIED;
            speed_now  = pick_speed(shortest);
            rep.speed  = speed_now;
         end
         rep.min_interval = shortest;
         rep.edge_total   = edges_seen;
         report_q.push_back(rep);
         open_window();
      end
   endtask

   function automatic int field_bad(input string field, input logic [31:0] want,
                                    input logic [31:0] got);
      if (got === want) begin
         return 0;
      end
      $error("%s: expected %0d, got %0d", field, want, got);
      return 1;
   endfunction

   always @(posedge clock) begin
      window_report_t want;
      if (reset) begin
         bit_ticks_cfg = SLOW_BIT_TICKS_RST;
         window_cfg    = WINDOW_TICKS_RST;
         need_cfg      = EDGES_NEEDED_RST;
         drop_cfg      = EDGES_DISCARDED_RST;
         line_q        = 1'b0;
         speed_now     = SPEED_125K;
         open_window();
         report_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_SLOW_BIT_TICKS:  bit_ticks_cfg = csr_wdata[SLOW_W-1:0];
               CSR_WINDOW_TICKS:    window_cfg    = csr_wdata[TICK_W-1:0];
               CSR_EDGES_NEEDED:    need_cfg      = csr_wdata[EDGE_W-1:0];
               CSR_EDGES_DISCARDED: drop_cfg      = csr_wdata[DISC_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            take_tick(req_mon.rx_level, req_mon.frame_seen);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (report_q.size() == 0) begin
               $error("result beat with no closed window: status %0d, edge_total %0d",
                      rsp_mon.status, rsp_mon.edge_total);
               fail_count++;
            end else begin
               want = report_q.pop_front();
               fail_count += field_bad("status", 32'(want.status), 32'(rsp_mon.status));
               fail_count += field_bad("speed_code", 32'(want.speed),
                                       32'(rsp_mon.speed_code));
               fail_count += field_bad("min_interval", want.min_interval,
                                       rsp_mon.min_interval);
               fail_count += field_bad("edge_total", 32'(want.edge_total),
                                       32'(rsp_mon.edge_total));
            end
         end
      end
      reports_due <= report_q.size();
   end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import cbrd_pkg::*;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;
   logic                 rsp_ready = 1'b0;

   int                   fail_count;
   int                   reports_due;

   int                   send_idle_pct = 0;
   int                   rsp_stall_pct = 0;
   logic                 hold_token = 1'b0;
   logic                 hold_seen = 1'b0;
   int                   hold_left = 0;
   int                   windows_done = 0;
   int                   ticks_sent = 0;
   logic                 line_lvl = 1'b0;
   int                   run_left = 0;

   can_req_if req_chan ();
   can_rsp_if rsp_chan ();

   assign rsp_chan.ready = rsp_ready;

   can_bit_rate_detector_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   cbrd_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .reports_due (reports_due)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hold off the result channel for a long stretch whenever the token flips
   always @(posedge clock) begin
      if (hold_token != hold_seen) begin
         hold_left <= 300;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
      hold_seen <= hold_token;
      if (rsp_chan.valid && rsp_ready) begin
         windows_done <= windows_done + 1;
      end
   end

   task automatic csr_write(input csr_index_type idx, input logic [CSR_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic program_regs(input logic [SLOW_W-1:0] slow, input logic [TICK_W-1:0] win,
                               input logic [EDGE_W-1:0] need, input logic [DISC_W-1:0] drop);
      csr_write(CSR_SLOW_BIT_TICKS, CSR_W'(slow));
      csr_write(CSR_WINDOW_TICKS, CSR_W'(win));
      csr_write(CSR_EDGES_NEEDED, CSR_W'(need));
      csr_write(CSR_EDGES_DISCARDED, CSR_W'(drop));
      csr_we <= 1'b0;
   endtask

   task automatic send_tick(input logic lvl, input logic frm);
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.rx_level   <= lvl;
      req_chan.frame_seen <= frm;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      ticks_sent++;
   endtask

   // bit-like runs of the line level with occasional short glitches
   task automatic run_ticks(input int count, input int bit_len, input int frame_odds);
      int n;
      for (n = 0; n < count; n++) begin
         if (run_left == 0) begin
            line_lvl = ~line_lvl;
            if ($urandom_range(0, 9) == 0) begin
               run_left = $urandom_range(1, 3);
            end else begin
               run_left = bit_len * $urandom_range(1, 5);
            end
         end
         run_left--;
         send_tick(line_lvl, frame_odds != 0 && $urandom_range(1, frame_odds) == 1);
      end
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      rsp_stall_pct  <= 0;
      @(posedge clock);
      while (reports_due != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   initial begin
      int                phase;
      int                sel;
      int                mode;
      logic [SLOW_W-1:0] slow;
      logic [TICK_W-1:0] win;
      logic [EDGE_W-1:0] need;
      logic [DISC_W-1:0] drop;
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      req_chan.valid      = 1'b0;
      req_chan.rx_level   = 1'b0;
      req_chan.frame_seen = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // zero-length window: every beat closes one
      program_regs(16, 0, 0, 0);
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b0);
      settle();

      program_regs(16, 12, 4, 1);
      for (int i = 0; i < 12; i++) begin
         send_tick(i[0], 1'b0);
      end
      settle();

      program_regs(16'hFFFF, 8, 8'hFF, 7'h7F);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b0);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b0);
      send_tick(1'b1, 1'b0);
      settle();
      line_lvl = 1'b1;

      // close on the edge limit only
      program_regs(16'hFFFF, 32'hFFFF_FFFF, 8'd128, 7'h7F);
      run_ticks(400, 1, 0);
      settle();

      program_regs(16'hFFFF, 40, 0, 0);
      send_idle_pct = 81;
      run_ticks(100, 2, 300);
      settle();

      // fill the block behind a stalled result channel
      program_regs(24, 2, 0, 0);
      send_idle_pct = 0;
      hold_token <= ~hold_token;
      run_ticks(80, 1, 0);
      settle();

      phase = 0;
      while (ticks_sent < 1350 || windows_done < 48) begin
         sel = $urandom_range(0, 9);
         if (sel < 7) begin
            slow = SLOW_W'($urandom_range(4, 48));
         end else if (sel == 7) begin
            slow = SLOW_W'($urandom_range(0, 3));
         end else if (sel == 8) begin
            slow = '1;
         end else begin
            slow = SLOW_W'($urandom());
         end
         sel = $urandom_range(0, 9);
         if (sel == 0) begin
            win = '0;
         end else if (sel == 1) begin
            win = TICK_W'($urandom_range(100, 300));
         end else begin
            win = TICK_W'($urandom_range(1, 60));
         end
         sel = $urandom_range(0, 9);
         if (sel < 7) begin
            need = EDGE_W'($urandom_range(0, 12));
         end else if (sel == 7) begin
            need = EDGE_W'(MAX_EDGES);
         end else if (sel == 8) begin
            need = '1;
         end else begin
            need = EDGE_W'($urandom());
         end
         sel = $urandom_range(0, 9);
         if (sel < 7) begin
            drop = DISC_W'($urandom_range(0, 4));
         end else if (sel == 7) begin
            drop = '1;
         end else begin
            drop = DISC_W'($urandom());
         end
         program_regs(slow, win, need, drop);

         mode = phase % 4;
         send_idle_pct = (mode == 1) ? 81 : (mode == 3) ? 26 : 0;
         rsp_stall_pct <= (mode == 2) ? 81 : (mode == 3) ? 26 : 0;
         sel = $urandom_range(0, 3);
         run_ticks($urandom_range(60, 140), $urandom_range(1, 12),
                   (sel == 0) ? 0 : (sel == 1) ? 300 : (sel == 2) ? 60 : 8);
         settle();
         phase++;
      end

      if (fail_count == 0 && reports_due == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Verification failed");
      $finish;
   end

endmodule
